// ----- design/wtge_pkg.sv -----
// ----------------------------------------------------------------------------
// wtge_pkg: shared types and constants for the wind triangle gust estimator
// Datapath widths, CORDIC gain and angle constants, arctangent table and the
// control struct that drives the shared CORDIC step unit.
// ----------------------------------------------------------------------------
package wtge_pkg;

	localparam int CW      = 40;   // CORDIC vector part width, 16 fraction bits
	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DW      = 48;   // gust divider operand width
	localparam int ITER_W  = 4;

	localparam logic [15:0] GAIN_Q16     = 16'd39797;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	typedef struct packed {
		logic              load;
		logic              step;
		logic              vec_mode;
		logic [ITER_W-1:0] iter;
	} cordic_ctl_t;

	function automatic logic [31:0] atan_angle(input logic [ITER_W-1:0] i);
		logic [31:0] a;
		case (i)
			4'd0:    a = 32'd536870912;
			4'd1:    a = 32'd316933406;
			4'd2:    a = 32'd167458907;
			4'd3:    a = 32'd85004756;
			4'd4:    a = 32'd42667331;
			4'd5:    a = 32'd21354465;
			4'd6:    a = 32'd10679838;
			4'd7:    a = 32'd5340245;
			4'd8:    a = 32'd2670163;
			4'd9:    a = 32'd1335087;
			4'd10:   a = 32'd667544;
			4'd11:   a = 32'd333772;
			4'd12:   a = 32'd166886;
			4'd13:   a = 32'd83443;
			4'd14:   a = 32'd41722;
			4'd15:   a = 32'd20861;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

// ----- design/wtge_if.sv -----
// ----------------------------------------------------------------------------
// wtge_in_if / wtge_out_if: valid-ready channels of the estimator
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface wtge_in_if;
	logic        valid;
	logic        ready;
	logic [13:0] true_airspeed;
	logic [13:0] ground_speed;
	logic [15:0] heading_angle;
	logic [15:0] track_angle;
	logic [13:0] ias_sample;

	modport source (output valid, true_airspeed, ground_speed, heading_angle,
		track_angle, ias_sample, input ready);
	modport sink (input valid, true_airspeed, ground_speed, heading_angle,
		track_angle, ias_sample, output ready);
endinterface

interface wtge_out_if;
	logic               valid;
	logic               ready;
	logic        [14:0] wind_speed;
	logic        [15:0] wind_direction;
	logic signed [15:0] headwind;
	logic signed [15:0] crosswind;
	logic        [15:0] gust_ratio;
	logic               gust_valid;

	modport source (output valid, wind_speed, wind_direction, headwind, crosswind,
		gust_ratio, gust_valid, input ready);
	modport sink (input valid, wind_speed, wind_direction, headwind, crosswind,
		gust_ratio, gust_valid, output ready);
endinterface

// ----- design/wtge_mul.sv -----
// ----------------------------------------------------------------------------
// wtge_mul: shared registered multiplier
// Unsigned product of the two operands, registered every cycle.
// ----------------------------------------------------------------------------
module wtge_mul (
	input  logic                           clk,
	input  logic [wtge_pkg::MUL_A_W-1:0]   a,
	input  logic [wtge_pkg::MUL_B_W-1:0]   b,
	output logic [wtge_pkg::MUL_P_W-1:0]   p
);

	logic [wtge_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= wtge_pkg::MUL_P_W'(a) * wtge_pkg::MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// ----- design/wtge_cordic.sv -----
// ----------------------------------------------------------------------------
// wtge_cordic: shared CORDIC step unit
// Holds x, y and angle; a load folds the start vector into the right half
// plane, and each step performs one rotation or vectoring micro-rotation.
// ----------------------------------------------------------------------------
module wtge_cordic (
	input  logic                           clk,
	input  wtge_pkg::cordic_ctl_t          ctl,
	input  logic signed [wtge_pkg::CW-1:0] load_x,
	input  logic signed [wtge_pkg::CW-1:0] load_y,
	input  logic        [31:0]             load_z,
	output logic signed [wtge_pkg::CW-1:0] x,
	output logic signed [wtge_pkg::CW-1:0] y,
	output logic        [31:0]             z
);

	logic signed [wtge_pkg::CW-1:0] x_q, y_q;
	logic        [31:0]             z_q;
	logic signed [wtge_pkg::CW-1:0] dx, dy;
	logic                           up;
	logic        [31:0]             za;

	// Arithmetic shift that truncates toward zero.
	function automatic logic signed [wtge_pkg::CW-1:0] tshift(
		input logic signed [wtge_pkg::CW-1:0] v, input logic [wtge_pkg::ITER_W-1:0] n);
		logic signed [wtge_pkg::CW-1:0] r;
		if (v < 0)
			r = -((-v) >>> n);
		else
			r = v >>> n;
		return r;
	endfunction

	always_comb begin
		dx = tshift(y_q, ctl.iter);
		dy = tshift(x_q, ctl.iter);
		za = wtge_pkg::atan_angle(ctl.iter);
		up = ctl.vec_mode ? (y_q > 0) : z_q[31];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.vec_mode) begin
				if (load_x < 0) begin
					x_q <= -load_x;
					y_q <= -load_y;
					z_q <= wtge_pkg::HALF_TURN;
				end else begin
					x_q <= load_x;
					y_q <= load_y;
					z_q <= 32'd0;
				end
			end else begin
				// Headings in the back half turn start from the negated vector.
				if ((load_z - wtge_pkg::QUARTER_TURN) < wtge_pkg::HALF_TURN) begin
					x_q <= -load_x;
					z_q <= load_z + wtge_pkg::HALF_TURN;
				end else begin
					x_q <= load_x;
					z_q <= load_z;
				end
				y_q <= load_y;
			end
		end else if (ctl.step) begin
			if (up) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + za;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - za;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule

// ----- design/wtge_divsqrt.sv -----
// ----------------------------------------------------------------------------
// wtge_divsqrt: gust ratio unit
// Restoring division giving 32 fraction bits of num/den, one bit a cycle,
// followed by a 16-step integer square root of the quotient.
// ----------------------------------------------------------------------------
module wtge_divsqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wtge_pkg::DW-1:0]    num,
	input  logic [wtge_pkg::DW-1:0]    den,
	output logic                       done,
	output logic [15:0]                root
);

	typedef enum logic [1:0] {DS_IDLE, DS_DIV, DS_SQRT} ds_state_t;

	ds_state_t                  state_q;
	logic [4:0]                 cnt_q;
	logic [wtge_pkg::DW-1:0]    r_q, den_q;
	logic [31:0]                q_q;
	logic [33:0]                v_q, res_q, bit_q;
	logic                       done_q;
	logic [wtge_pkg::DW-1:0]    r2;
	logic [33:0]                t;

	always_comb begin
		r2 = {r_q[wtge_pkg::DW-2:0], 1'b0};
		t  = res_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q   <= '0;
			r_q     <= '0;
			den_q   <= '0;
			q_q     <= '0;
			v_q     <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DS_IDLE: begin
					if (start) begin
						r_q     <= num;
						den_q   <= den;
						q_q     <= '0;
						cnt_q   <= '0;
						state_q <= DS_DIV;
					end
				end
				DS_DIV: begin
					if (r2 >= den_q) begin
						r_q <= r2 - den_q;
						q_q <= {q_q[30:0], 1'b1};
					end else begin
						r_q <= r2;
						q_q <= {q_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= DS_SQRT;
						res_q   <= '0;
						bit_q   <= 34'd1 << 30;
						cnt_q   <= '0;
					end
				end
				DS_SQRT: begin
					if (cnt_q == 5'd0)
						v_q <= {2'b00, q_q};
					if (cnt_q != 5'd0) begin
						if (v_q >= t) begin
							v_q   <= v_q - t;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= DS_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign root = res_q[15:0];

endmodule

// ----- design/wind_triangle_gust_estimator.sv -----
// ----------------------------------------------------------------------------
// wind_triangle_gust_estimator: wind triangle solution and gust factor
// Solves wind speed, direction, headwind and crosswind with a shared CORDIC
// unit and a shared multiplier, and tracks an IAS window for the gust ratio.
// ----------------------------------------------------------------------------
// An item whose gust ratio is computed runs, from acceptance to the result
// beat, through the window update, four 16-step CORDIC passes on the single
// shared CORDIC unit (air vector, ground vector, wind vectoring, track
// rotation) with their load and multiplier states, the forming of the ratio
// operands, the 32-step division and 16-step square root, and the output
// state. Without a valid ratio, or when the ratio saturates, the division is
// skipped; a zero wind vector skips the vectoring pass.
// The input is ready only while the sequencer is idle, so the next item can
// be taken in the cycle after the result is registered; a finished result waits
// in the output register while the next item is already taken, and a result
// that cannot leave stalls the sequencer in its output cycle.
// The IAS window is a memory of WINDOW_DEPTH entries; an old entry is only
// used once it has been written, so the memory needs no clearing after reset.
module wind_triangle_gust_estimator #(
	parameter int WINDOW_DEPTH = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [4:0]        cfg_wr_data,
	wtge_in_if.sink           sample,
	wtge_out_if.source        result
);

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = 14 + CNT_W;
	localparam int SQ_W   = 28 + CNT_W;
	localparam int CW     = wtge_pkg::CW;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ_OLD, ST_SQ_NEW, ST_SQ_UPD,
		ST_A_LD, ST_A_RUN, ST_G_MUL, ST_G_LD, ST_G_RUN,
		ST_V_LD, ST_V_RUN, ST_SPD_MUL, ST_SPD,
		ST_R_MUL, ST_R_LD, ST_R_RUN,
		ST_GA, ST_GB, ST_GC, ST_GW, ST_OUT
	} state_t;

	state_t                 state_q;
	logic [4:0]             min_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       count_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   full_q;
	logic [wtge_pkg::ITER_W-1:0] iter_q;

	logic [13:0]            tas_q, gs_q, ias_q, old_q;
	logic [15:0]            hdg_q, trk_q;
	logic signed [CW-1:0]   ae_q, an_q;
	logic [31:0]            dir_q;
	logic [14:0]            speed_q;
	logic signed [15:0]     hw_q, cw_q;
	logic [wtge_pkg::DW-1:0] a_q;
	logic [15:0]            gust_q;
	logic                   gvalid_q;

	logic                   out_valid_q;
	logic [14:0]            o_speed_q;
	logic [15:0]            o_dir_q, o_gust_q;
	logic signed [15:0]     o_hw_q, o_cw_q;
	logic                   o_gvalid_q;

	logic [13:0]            win_mem [WINDOW_DEPTH];

	logic [wtge_pkg::MUL_A_W-1:0] mul_a;
	logic [wtge_pkg::MUL_B_W-1:0] mul_b;
	logic [wtge_pkg::MUL_P_W-1:0] mul_p;

	wtge_pkg::cordic_ctl_t  cctl;
	logic signed [CW-1:0]   c_lx, c_ly, c_x, c_y;
	logic [31:0]            c_lz, c_z;

	logic                   ds_start, ds_done;
	logic [15:0]            ds_root;

	logic                   accept;
	logic signed [CW-1:0]   we, wn;
	logic [wtge_pkg::MUL_P_W-1:0] spd_round;
	logic [wtge_pkg::DW-1:0] s2, dval;
	logic                   gok;
	logic                   iter_last;

	function automatic logic signed [CW-1:0] round16(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		if (v >= 0)
			r = (v + CW'(32768)) >>> 16;
		else
			r = -((-v + CW'(32768)) >>> 16);
		return r;
	endfunction

	function automatic logic signed [15:0] clamp16(input logic signed [CW-1:0] v);
		logic signed [15:0] r;
		if (v > CW'(32767))
			r = 16'sd32767;
		else if (v < -CW'(32768))
			r = -16'sd32768;
		else
			r = v[15:0];
		return r;
	endfunction

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign iter_last    = (iter_q == {wtge_pkg::ITER_W{1'b1}});

	always_ff @(posedge clk) begin
		if (accept) begin
			old_q           <= win_mem[slot_q];
			win_mem[slot_q] <= sample.ias_sample;
		end
	end

	wtge_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	wtge_cordic u_cordic (
		.clk(clk), .ctl(cctl), .load_x(c_lx), .load_y(c_ly), .load_z(c_lz),
		.x(c_x), .y(c_y), .z(c_z)
	);

	wtge_divsqrt u_divsqrt (
		.clk(clk), .arst_n(arst_n), .start(ds_start), .num(dval), .den(s2),
		.done(ds_done), .root(ds_root)
	);

	always_comb begin
		we        = c_y - ae_q;
		wn        = c_x - an_q;
		spd_round = mul_p + (wtge_pkg::MUL_P_W'(1) << 31);
		s2        = mul_p[wtge_pkg::DW-1:0];
		dval      = (a_q > s2) ? (a_q - s2) : '0;
		gok       = (8'(count_q) >= 8'(min_q)) && (sum_q != '0);
		ds_start  = (state_q == ST_GC) && gok && (dval < s2);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ_OLD: begin
				mul_a = wtge_pkg::MUL_A_W'(old_q);
				mul_b = wtge_pkg::MUL_B_W'(old_q);
			end
			ST_SQ_NEW: begin
				mul_a = wtge_pkg::MUL_A_W'(ias_q);
				mul_b = wtge_pkg::MUL_B_W'(ias_q);
			end
			ST_SQ_UPD: begin
				mul_a = wtge_pkg::MUL_A_W'(tas_q);
				mul_b = wtge_pkg::MUL_B_W'(wtge_pkg::GAIN_Q16);
			end
			ST_G_MUL: begin
				mul_a = wtge_pkg::MUL_A_W'(gs_q);
				mul_b = wtge_pkg::MUL_B_W'(wtge_pkg::GAIN_Q16);
			end
			ST_SPD_MUL: begin
				mul_a = wtge_pkg::MUL_A_W'(c_x);
				mul_b = wtge_pkg::MUL_B_W'(wtge_pkg::GAIN_Q16);
			end
			ST_R_MUL: begin
				mul_a = wtge_pkg::MUL_A_W'(speed_q);
				mul_b = wtge_pkg::MUL_B_W'(wtge_pkg::GAIN_Q16);
			end
			ST_GA: begin
				mul_a = wtge_pkg::MUL_A_W'(sq_q);
				mul_b = wtge_pkg::MUL_B_W'(count_q);
			end
			ST_GB: begin
				mul_a = wtge_pkg::MUL_A_W'(sum_q);
				mul_b = wtge_pkg::MUL_B_W'(sum_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// CORDIC control: rotation loads take the fresh product as magnitude.
	always_comb begin
		cctl.load     = 1'b0;
		cctl.step     = 1'b0;
		cctl.vec_mode = 1'b0;
		cctl.iter     = iter_q;
		c_lx          = $signed(mul_p[CW-1:0]);
		c_ly          = '0;
		c_lz          = '0;
		case (state_q)
			ST_A_LD: begin
				cctl.load = 1'b1;
				c_lz      = {hdg_q, 16'h0000};
			end
			ST_G_LD: begin
				cctl.load = 1'b1;
				c_lz      = {trk_q, 16'h0000};
			end
			ST_R_LD: begin
				cctl.load = 1'b1;
				c_lz      = dir_q - {trk_q, 16'h0000};
			end
			ST_V_LD: begin
				cctl.load     = (we != '0) || (wn != '0);
				cctl.vec_mode = 1'b1;
				c_lx          = wn;
				c_ly          = we;
			end
			ST_V_RUN: begin
				cctl.step     = 1'b1;
				cctl.vec_mode = 1'b1;
			end
			ST_A_RUN, ST_G_RUN, ST_R_RUN: begin
				cctl.step = 1'b1;
			end
			default: begin
				cctl.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_q       <= 5'd2;
			slot_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			full_q      <= 1'b0;
			iter_q      <= '0;
			tas_q       <= '0;
			gs_q        <= '0;
			ias_q       <= '0;
			hdg_q       <= '0;
			trk_q       <= '0;
			ae_q        <= '0;
			an_q        <= '0;
			dir_q       <= '0;
			speed_q     <= '0;
			hw_q        <= '0;
			cw_q        <= '0;
			a_q         <= '0;
			gust_q      <= '0;
			gvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
			o_speed_q   <= '0;
			o_dir_q     <= '0;
			o_hw_q      <= '0;
			o_cw_q      <= '0;
			o_gust_q    <= '0;
			o_gvalid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				min_q <= cfg_wr_data;
			// The output cycle refills the register itself when the beat leaves.
			if (out_valid_q && result.ready && (state_q != ST_OUT))
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tas_q   <= sample.true_airspeed;
						gs_q    <= sample.ground_speed;
						hdg_q   <= sample.heading_angle;
						trk_q   <= sample.track_angle;
						ias_q   <= sample.ias_sample;
						full_q  <= (count_q == CNT_W'(WINDOW_DEPTH));
						state_q <= ST_SQ_OLD;
					end
				end
				ST_SQ_OLD: state_q <= ST_SQ_NEW;
				ST_SQ_NEW: begin
					// A full window drops the sample being overwritten.
					if (full_q) begin
						sq_q  <= sq_q - mul_p[SQ_W-1:0];
						sum_q <= sum_q - SUM_W'(old_q);
					end
					state_q <= ST_SQ_UPD;
				end
				ST_SQ_UPD: begin
					sq_q  <= sq_q + mul_p[SQ_W-1:0];
					sum_q <= sum_q + SUM_W'(ias_q);
					if (slot_q == SLOT_W'(WINDOW_DEPTH - 1))
						slot_q <= '0;
					else
						slot_q <= slot_q + SLOT_W'(1);
					if (!full_q)
						count_q <= count_q + CNT_W'(1);
					state_q <= ST_A_LD;
				end
				ST_A_LD: begin
					iter_q  <= '0;
					state_q <= ST_A_RUN;
				end
				ST_A_RUN: begin
					iter_q <= iter_q + 1'b1;
					if (iter_last)
						state_q <= ST_G_MUL;
				end
				ST_G_MUL: begin
					ae_q    <= c_y;
					an_q    <= c_x;
					state_q <= ST_G_LD;
				end
				ST_G_LD: begin
					iter_q  <= '0;
					state_q <= ST_G_RUN;
				end
				ST_G_RUN: begin
					iter_q <= iter_q + 1'b1;
					if (iter_last)
						state_q <= ST_V_LD;
				end
				ST_V_LD: begin
					iter_q <= '0;
					if ((we == '0) && (wn == '0)) begin
						speed_q <= '0;
						dir_q   <= '0;
						state_q <= ST_R_MUL;
					end else begin
						state_q <= ST_V_RUN;
					end
				end
				ST_V_RUN: begin
					iter_q <= iter_q + 1'b1;
					if (iter_last)
						state_q <= ST_SPD_MUL;
				end
				ST_SPD_MUL: begin
					dir_q   <= c_z;
					state_q <= ST_SPD;
				end
				ST_SPD: begin
					if (spd_round[wtge_pkg::MUL_P_W-1:32] > 32'd32767)
						speed_q <= 15'd32767;
					else
						speed_q <= spd_round[46:32];
					state_q <= ST_R_MUL;
				end
				ST_R_MUL: state_q <= ST_R_LD;
				ST_R_LD: begin
					iter_q  <= '0;
					state_q <= ST_R_RUN;
				end
				ST_R_RUN: begin
					iter_q <= iter_q + 1'b1;
					if (iter_last)
						state_q <= ST_GA;
				end
				ST_GA: begin
					hw_q    <= clamp16(-round16(c_x));
					cw_q    <= clamp16(round16(c_y));
					state_q <= ST_GB;
				end
				ST_GB: begin
					a_q     <= mul_p[wtge_pkg::DW-1:0];
					state_q <= ST_GC;
				end
				ST_GC: begin
					gvalid_q <= gok;
					if (!gok) begin
						gust_q  <= '0;
						state_q <= ST_OUT;
					end else if (dval >= s2) begin
						gust_q  <= 16'hFFFF;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_GW;
					end
				end
				ST_GW: begin
					if (ds_done) begin
						gust_q  <= ds_root;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						o_speed_q   <= speed_q;
						o_dir_q     <= 16'((dir_q + 32'h0000_8000) >> 16);
						o_hw_q      <= hw_q;
						o_cw_q      <= cw_q;
						o_gust_q    <= gust_q;
						o_gvalid_q  <= gvalid_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid          = out_valid_q;
	assign result.wind_speed     = o_speed_q;
	assign result.wind_direction = o_dir_q;
	assign result.headwind       = o_hw_q;
	assign result.crosswind      = o_cw_q;
	assign result.gust_ratio     = o_gust_q;
	assign result.gust_valid     = o_gvalid_q;

endmodule

// ----- dv/wtge_in_drv_if.sv -----
// ----------------------------------------------------------------------------
// wtge_tb_pkg: constants shared by the estimator testbench
// The channel interfaces themselves come with the design; this file only
// holds the small set of constants that the testbench shares between tasks.
// ----------------------------------------------------------------------------
package wtge_tb_pkg;

	localparam int WIN_DEPTH   = 20;
	localparam int ITEM_CYCLES = 140;
	localparam int IDLE_PCT    = 29;

endpackage

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the wind triangle gust estimator
// Drives air data beats with random gaps and result stalls, predicts every
// wind and gust result with a bit-accurate CORDIC and window model, and
// compares all fields of each result beat in order.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic [14:0] wind_speed;
		logic [15:0] wind_direction;
		logic [15:0] headwind;
		logic [15:0] crosswind;
		logic [15:0] gust_ratio;
		logic        gust_valid;
	} wind_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [4:0] cfg_wr_data;

	wtge_in_if  sample();
	wtge_out_if result();

	wind_triangle_gust_estimator #(.WINDOW_DEPTH(wtge_tb_pkg::WIN_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.sample(sample.sink), .result(result.source)
	);

	// Predictor state
	logic [13:0]  ias_ring [wtge_tb_pkg::WIN_DEPTH];
	int unsigned  ring_slot;
	int unsigned  ring_count;
	longint unsigned ias_sum;
	longint unsigned ias_sum_sq;
	logic [4:0]   min_count;

	wind_result_t expected_results[$];
	int mismatches;
	int results_seen;
	int gust_valid_seen;
	int idle_cycles;
	bit calm_mode;     // no idling on either side
	bit hold_sink;     // long receiver hold-off
	bit timed_out;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint atan_step(input int i);
		longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861};
		return t[i];
	endfunction

	// Signed division by a power of two, truncating toward zero.
	function automatic longint trunc_shift(input longint v, input int n);
		return v / (longint'(1) <<< n);
	endfunction

	function automatic longint round_away(input longint v, input int n);
		longint half;
		half = longint'(1) <<< (n - 1);
		if (v >= 0) return (v + half) / (longint'(1) <<< n);
		return -((-v + half) / (longint'(1) <<< n));
	endfunction

	function automatic longint sat16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	task automatic cordic_rotate(input longint mag, input logic [31:0] ang,
			output longint east, output longint north);
		longint x, y, dx, dy;
		logic [31:0] z;
		logic [31:0] off;
		x = mag * longint'(wtge_pkg::GAIN_Q16);
		y = 0;
		z = ang;
		off = z - wtge_pkg::QUARTER_TURN;
		if (off < wtge_pkg::HALF_TURN) begin
			x = -x;
			z = z + wtge_pkg::HALF_TURN;
		end
		for (int i = 0; i < 16; i++) begin
			dx = trunc_shift(y, i);
			dy = trunc_shift(x, i);
			if (z[31]) begin
				x += dx; y -= dy; z = z + 32'(atan_step(i));
			end else begin
				x -= dx; y += dy; z = z - 32'(atan_step(i));
			end
		end
		east = y;
		north = x;
	endtask

	task automatic cordic_vector(input longint east, input longint north,
			output longint mag, output logic [31:0] ang);
		longint x, y, dx, dy;
		logic [31:0] z;
		x = north;
		y = east;
		z = '0;
		if (x < 0) begin
			x = -x; y = -y; z = wtge_pkg::HALF_TURN;
		end
		for (int i = 0; i < 16; i++) begin
			dx = trunc_shift(y, i);
			dy = trunc_shift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z = z + 32'(atan_step(i));
			end else begin
				x -= dx; y += dy; z = z - 32'(atan_step(i));
			end
		end
		mag = x;
		ang = z;
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 30;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	task automatic predict_wind(input logic [13:0] tas, input logic [13:0] gs,
			input logic [15:0] hdg, input logic [15:0] trk, input logic [13:0] ias);
		longint ae, an, ge, gn, we, wn, vmag, speed, re, rn;
		logic [31:0] dir32, trk32;
		longint unsigned old, a, s2, d, r, q, gust;
		wind_result_t res;
		res = '0;
		gust = 0;
		if (ring_slot >= wtge_tb_pkg::WIN_DEPTH) ring_slot = 0;
		if (ring_count >= wtge_tb_pkg::WIN_DEPTH) begin
			old = ias_ring[ring_slot];
			ias_sum -= old;
			ias_sum_sq -= old * old;
			ring_count = wtge_tb_pkg::WIN_DEPTH;
		end
		ias_ring[ring_slot] = ias;
		ias_sum += ias;
		ias_sum_sq += longint'(ias) * longint'(ias);
		ring_slot = (ring_slot + 1) % wtge_tb_pkg::WIN_DEPTH;
		if (ring_count < wtge_tb_pkg::WIN_DEPTH) ring_count++;

		trk32 = {trk, 16'h0};
		cordic_rotate(longint'(tas), {hdg, 16'h0}, ae, an);
		cordic_rotate(longint'(gs), trk32, ge, gn);
		we = ge - ae;
		wn = gn - an;
		dir32 = '0;
		if (we == 0 && wn == 0) begin
			speed = 0;
		end else begin
			cordic_vector(we, wn, vmag, dir32);
			speed = round_away(vmag * longint'(wtge_pkg::GAIN_Q16), 32);
			if (speed > 32767) speed = 32767;
			if (speed < 0) speed = 0;
		end
		cordic_rotate(speed, dir32 - trk32, re, rn);

		if (ring_count >= min_count && ias_sum != 0) begin
			a = ring_count * ias_sum_sq;
			s2 = ias_sum * ias_sum;
			d = (a > s2) ? a - s2 : 0;
			res.gust_valid = 1'b1;
			if (d >= s2) begin
				gust = 65535;
			end else begin
				r = d;
				q = 0;
				for (int k = 0; k < 32; k++) begin
					r <<= 1;
					q <<= 1;
					if (r >= s2) begin
						r -= s2;
						q |= 1;
					end
				end
				gust = int_sqrt(q);
				if (gust > 65535) gust = 65535;
			end
		end
		res.wind_speed = 15'(speed);
		res.wind_direction = 16'((dir32 + 32'h8000) >> 16);
		res.headwind = 16'(sat16(-round_away(rn, 16)));
		res.crosswind = 16'(sat16(round_away(re, 16)));
		res.gust_ratio = 16'(gust);
		expected_results.push_back(res);
	endtask

	// Sends one beat and runs the prediction once it is accepted. Valid stays
	// high after the beat until the next send or a drain decides otherwise.
	task automatic send_air_data(input logic [13:0] tas, input logic [13:0] gs,
			input logic [15:0] hdg, input logic [15:0] trk, input logic [13:0] ias);
		@(negedge clk);
		while (!calm_mode && $urandom_range(99) < wtge_tb_pkg::IDLE_PCT) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid <= 1'b1;
		sample.true_airspeed <= tas;
		sample.ground_speed <= gs;
		sample.heading_angle <= hdg;
		sample.track_angle <= trk;
		sample.ias_sample <= ias;
		do @(posedge clk); while (!sample.ready);
		predict_wind(tas, gs, hdg, trk, ias);
	endtask

	task automatic send_random(input int unsigned ias_hi);
		send_air_data(14'($urandom), 14'($urandom), 16'($urandom), 16'($urandom),
			14'($urandom_range(ias_hi)));
	endtask

	task automatic drain_results();
		@(negedge clk);
		sample.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (wtge_tb_pkg::ITEM_CYCLES) @(negedge clk);
	endtask

	task automatic write_min_count(input logic [4:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		min_count = v;
	endtask

	// Receiver: random stalls unless calm or held off.
	always @(negedge clk) begin
		if (!arst_n) result.ready <= 1'b0;
		else result.ready <= !hold_sink &&
			(calm_mode || $urandom_range(99) >= wtge_tb_pkg::IDLE_PCT);
	end

	always @(posedge clk) begin
		wind_result_t got, want;
		if (arst_n && result.valid && result.ready) begin
			got = {result.wind_speed, result.wind_direction, result.headwind,
				result.crosswind, result.gust_ratio, result.gust_valid};
			results_seen++;
			if (got.gust_valid) gust_valid_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result beat %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at result %0d: expected %p, got %p",
							results_seen, want, got);
				end
			end
		end
	end

	// Watchdog on cycles with no accepted beat.
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) timed_out <= 1'b1;
	end

	always @(posedge timed_out) begin
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic test_extremes();
		send_air_data(14'd0, 14'd0, 16'd0, 16'd0, 14'd0);
		send_air_data(14'd0, 14'd0, 16'hFFFF, 16'h1234, 14'd0);
		send_air_data(14'h3FFF, 14'h3FFF, 16'd0, 16'h8000, 14'h3FFF);
		send_air_data(14'h3FFF, 14'h3FFF, 16'h4000, 16'hC000, 14'h3FFF);
		send_air_data(14'h3FFF, 14'd0, 16'hFFFF, 16'hFFFF, 14'd1);
		send_air_data(14'd0, 14'h3FFF, 16'h8000, 16'h7FFF, 14'd1000);
		send_air_data(14'd1600, 14'd1600, 16'h2000, 16'h2000, 14'd1000);
		send_air_data(14'd1, 14'd2, 16'h0001, 16'hFFFE, 14'h2AAA);
		send_air_data(14'h2AAA, 14'h1555, 16'hAAAA, 16'h5555, 14'h1555);
	endtask

	task automatic test_gust_window();
		write_min_count(5'd1);
		repeat (3) send_air_data(14'd800, 14'd900, 16'h1000, 16'h1100, 14'd0);
		send_air_data(14'd800, 14'd900, 16'h1000, 16'h1100, 14'h3FFF);
		write_min_count(5'd20);
		repeat (24) send_random(16383);
		write_min_count(5'd31);
		repeat (6) send_random(16383);
		write_min_count(5'd0);
		repeat (4) send_random(3);
	endtask

	task automatic test_back_pressure();
		hold_sink = 1'b1;
		fork
			begin
				repeat (wtge_tb_pkg::ITEM_CYCLES * 4) @(negedge clk);
				hold_sink = 1'b0;
			end
			repeat (6) send_random(16383);
		join
		drain_results();
	endtask

	task automatic test_random();
		logic [4:0] settings[4] = '{5'd2, 5'd10, 5'd1, 5'd20};
		for (int p = 0; p < 4; p++) begin
			write_min_count(settings[p]);
			calm_mode = (p == 2);
			for (int i = 0; i < 160; i++) begin
				// Mostly steady air with small gusts, some fully random samples.
				if ($urandom_range(3) != 0)
					send_air_data(14'($urandom_range(3000)), 14'($urandom_range(3000)),
						16'($urandom), 16'($urandom), 14'(1500 + $urandom_range(200)));
				else
					send_random(16383);
			end
		end
		calm_mode = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sample.valid = 1'b0;
		sample.true_airspeed = '0;
		sample.ground_speed = '0;
		sample.heading_angle = '0;
		sample.track_angle = '0;
		sample.ias_sample = '0;
		result.ready = 1'b0;
		ring_slot = 0;
		ring_count = 0;
		ias_sum = 0;
		ias_sum_sq = 0;
		min_count = 5'd2;
		mismatches = 0;
		results_seen = 0;
		gust_valid_seen = 0;
		idle_cycles = 0;
		calm_mode = 1'b0;
		hold_sink = 1'b0;
		timed_out = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_gust_window();
		test_back_pressure();
		test_random();
		drain_results();

		$display("Checked %0d wind results, %0d with a valid gust factor,",
			results_seen, gust_valid_seen);
		$display("over min sample settings 0 to 31, stalls and a long hold-off.");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
